FILE: design/swm_pkg.sv
package swm_pkg;

  // Fixed field widths of the request channels.
  localparam int HashWidth = 64;
  localparam int PosOutWidth = 16;
  localparam int WinCfgWidth = 7;

  // Defaults for the top level parameters.
  localparam int DefMaxWindow = 64;
  localparam int DefMaxReadHashes = 65536;

  // Window size after reset.
  localparam logic [WinCfgWidth-1:0] WinSizeReset = 7'd16;

  typedef struct packed {
    logic [HashWidth-1:0] hash_value;
    logic                 start_of_read;
  } in_req_t;

  typedef struct packed {
    logic [HashWidth-1:0]   minimizer;
    logic [PosOutWidth-1:0] position;
    logic                   too_long;
  } out_req_t;

endpackage

FILE: design/swm_cell.sv
module swm_cell #(
  parameter int POS_W = 16
) (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [swm_pkg::HashWidth-1:0] hash,
  input  logic [POS_W-1:0]            pos,
  input  logic [swm_pkg::HashWidth-1:0] prev_value,
  input  logic [POS_W-1:0]            prev_pos,
  output logic [swm_pkg::HashWidth-1:0] min_value,
  output logic [POS_W-1:0]            min_pos
);
  import swm_pkg::*;

  logic [HashWidth-1:0] value_r;
  logic [HashWidth-1:0] value_nxt;
  logic [POS_W-1:0]     pos_r;
  logic [POS_W-1:0]     pos_nxt;

  // The cell holds the right-most minimum of the newest hashes up to its depth.
  // It extends its neighbor's span by the incoming hash; ties go to the newer hash.
  always_comb begin
    if (hash <= prev_value) begin
      value_nxt = hash;
      pos_nxt   = pos;
    end else begin
      value_nxt = prev_value;
      pos_nxt   = prev_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      value_r <= value_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign min_value = value_r;
  assign min_pos   = pos_r;

endmodule

FILE: design/swm_tracker.sv
module swm_tracker #(
  parameter int MAX_WINDOW = swm_pkg::DefMaxWindow,
  parameter int MAX_READ_HASHES = swm_pkg::DefMaxReadHashes,
  localparam int PW = $clog2(MAX_READ_HASHES),
  localparam int CW = $clog2(MAX_READ_HASHES + 1),
  localparam int WNW = $clog2(MAX_WINDOW + 1),
  localparam int XW = (CW > WNW) ? CW : WNW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  swm_pkg::in_req_t              in_req,
  input  logic [XW-1:0]                 win_len,
  input  logic [swm_pkg::HashWidth-1:0] prev_value,
  input  logic [PW-1:0]                 prev_pos,
  output logic                          store,
  output logic [PW-1:0]                 cur_pos,
  output logic                          res_valid,
  output swm_pkg::out_req_t             res,
  output logic [CW-1:0]                 count
);
  import swm_pkg::*;

  localparam int PXW = (PW > PosOutWidth) ? PW : PosOutWidth + 1;

  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;
  logic [HashWidth-1:0] min_value_r;
  logic [HashWidth-1:0] min_value_nxt;
  logic [PW-1:0]        min_pos_r;
  logic [PW-1:0]        min_pos_nxt;
  logic                 min_valid_r;
  logic                 min_valid_nxt;
  logic [PW-1:0]        last_pos_r;
  logic [PW-1:0]        last_pos_nxt;
  logic                 emit_valid_r;
  logic                 emit_valid_nxt;

  // State as seen by this request, after an optional start of read.
  logic [CW-1:0]        cnt_eff;
  logic                 min_valid_eff;
  logic                 emit_valid_eff;
  logic [CW-1:0]        cnt_inc;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        left_x;
  logic                 saturated;
  logic                 window_full;
  logic                 rescan;
  logic [HashWidth-1:0] cand_value;
  logic [PW-1:0]        cand_pos;
  logic [HashWidth-1:0] sel_value;
  logic [PW-1:0]        sel_pos;
  logic [PXW-1:0]       pos_ext;
  logic                 hash_wins;

  assign cnt_eff        = in_req.start_of_read ? '0 : cnt_r;
  assign min_valid_eff  = in_req.start_of_read ? 1'b0 : min_valid_r;
  assign emit_valid_eff = in_req.start_of_read ? 1'b0 : emit_valid_r;
  assign saturated      = (cnt_eff >= CW'(MAX_READ_HASHES));
  assign cur_pos        = cnt_eff[PW-1:0];
  assign cnt_inc        = cnt_eff + 1'b1;
  assign cnt_x          = XW'(cnt_inc);
  assign window_full    = (cnt_x >= win_len);
  assign left_x         = cnt_x - win_len;
  assign store          = step && !saturated;

  // Full-window candidate: the chain entry one short of the window, extended
  // by the incoming hash.
  always_comb begin
    if (in_req.hash_value <= prev_value) begin
      cand_value = in_req.hash_value;
      cand_pos   = cur_pos;
    end else begin
      cand_value = prev_value;
      cand_pos   = prev_pos;
    end
  end

  // A rescan is needed when there is no minimum yet or it left the window.
  assign rescan    = !min_valid_eff || (XW'(min_pos_r) < left_x);
  assign hash_wins = (in_req.hash_value <= min_value_r);

  always_comb begin
    if (rescan) begin
      sel_value = cand_value;
      sel_pos   = cand_pos;
    end else if (hash_wins) begin
      sel_value = in_req.hash_value;
      sel_pos   = cur_pos;
    end else begin
      sel_value = min_value_r;
      sel_pos   = min_pos_r;
    end
  end

  // Next state of the per-read registers.
  always_comb begin
    cnt_nxt        = cnt_r;
    min_value_nxt  = min_value_r;
    min_pos_nxt    = min_pos_r;
    min_valid_nxt  = min_valid_r;
    last_pos_nxt   = last_pos_r;
    emit_valid_nxt = emit_valid_r;
    res_valid      = 1'b0;
    pos_ext        = PXW'(sel_pos);
    res.minimizer  = sel_value;
    res.position   = pos_ext[PosOutWidth-1:0];
    res.too_long   = |pos_ext[PXW-1:PosOutWidth];
    if (step) begin
      if (saturated) begin
        res_valid    = 1'b1;
        res.minimizer = '0;
        res.position = '0;
        res.too_long = 1'b1;
      end else begin
        cnt_nxt        = cnt_inc;
        min_valid_nxt  = min_valid_eff;
        emit_valid_nxt = emit_valid_eff;
        if (in_req.start_of_read) begin
          min_value_nxt = '0;
          min_pos_nxt   = '0;
          last_pos_nxt  = '0;
        end
        if (window_full) begin
          min_value_nxt = sel_value;
          min_pos_nxt   = sel_pos;
          min_valid_nxt = 1'b1;
          if (!emit_valid_eff || (sel_pos > last_pos_r)) begin
            res_valid      = 1'b1;
            emit_valid_nxt = 1'b1;
            last_pos_nxt   = sel_pos;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      min_valid_r  <= 1'b0;
      emit_valid_r <= 1'b0;
      min_value_r  <= '0;
      min_pos_r    <= '0;
      last_pos_r   <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      min_valid_r  <= min_valid_nxt;
      emit_valid_r <= emit_valid_nxt;
      min_value_r  <= min_value_nxt;
      min_pos_r    <= min_pos_nxt;
      last_pos_r   <= last_pos_nxt;
    end
  end

  assign count = cnt_r;

endmodule

FILE: design/sliding_window_minimizer.sv
// Channel  Ports                                 Payload
// -------  ------------------------------------  ---------------------------------
// in       in_valid, in_ready, in_data           hash_value, start_of_read
// out      out_valid, out_ready, out_data        minimizer, position, too_long
// cfg      cfg_valid, cfg_ready, cfg_data        window_size (always ready)
//
// One request is taken per cycle; a result, if any, appears on out the cycle after its request.
// The throughput limit is the single output register: in_ready drops only while a
// result waits there and out_ready is low.
// Each stored hash shifts a chain of MAX_WINDOW-1 compare cells; the selected cell gives the
// window minimum on a rescan, so no request ever waits for a scan.
// Reset clears the read state and sets window_size to 16; no clearing pass is needed.
module sliding_window_minimizer #(
  parameter int MAX_WINDOW = swm_pkg::DefMaxWindow,
  parameter int MAX_READ_HASHES = swm_pkg::DefMaxReadHashes
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swm_pkg::in_req_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swm_pkg::out_req_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swm_pkg::WinCfgWidth-1:0] cfg_data
);
  import swm_pkg::*;

  localparam int PW = $clog2(MAX_READ_HASHES);
  localparam int CW = $clog2(MAX_READ_HASHES + 1);
  localparam int WNW = $clog2(MAX_WINDOW + 1);
  localparam int XW = (CW > WNW) ? CW : WNW;
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [WinCfgWidth-1:0] win_size_r;
  logic [WinCfgWidth-1:0] win_size_nxt;
  logic [XW-1:0]          win_ext;
  logic [XW-1:0]          win_len;
  logic [XW-1:0]          win_m1;
  logic [IW-1:0]          sel;

  logic                   step;
  logic                   store;
  logic [PW-1:0]          cur_pos;
  logic                   res_valid;
  out_req_t               res;
  logic [CW-1:0]          count;

  logic [HashWidth-1:0]   chain_value [MAX_WINDOW];
  logic [PW-1:0]          chain_pos   [MAX_WINDOW];

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_req_t               out_data_r;

  // Configuration register; writes are always taken.
  assign cfg_ready    = 1'b1;
  assign win_size_nxt = cfg_valid ? cfg_data : win_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WinSizeReset;
    end else begin
      win_size_r <= win_size_nxt;
    end
  end

  // Effective window length: zero acts as one, large values clamp to the chain depth.
  assign win_ext = XW'(win_size_r);

  always_comb begin
    if (win_ext == '0) begin
      win_len = XW'(1);
    end else if (win_ext > XW'(MAX_WINDOW)) begin
      win_len = XW'(MAX_WINDOW);
    end else begin
      win_len = win_ext;
    end
  end

  assign win_m1 = win_len - 1'b1;
  assign sel    = win_m1[IW-1:0];

  // Handshake: a new request enters whenever the output register can take a result.
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  // Head of the chain is the incoming hash itself.
  assign chain_value[0] = in_data.hash_value;
  assign chain_pos[0]   = cur_pos;

  for (genvar i = 0; i < MAX_WINDOW - 1; i++) begin : g_cell
    swm_cell #(
      .POS_W(PW)
    ) u_cell (
      .clk        (clk),
      .shift      (store),
      .hash       (in_data.hash_value),
      .pos        (cur_pos),
      .prev_value (chain_value[i]),
      .prev_pos   (chain_pos[i]),
      .min_value  (chain_value[i+1]),
      .min_pos    (chain_pos[i+1])
    );
  end

  swm_tracker #(
    .MAX_WINDOW      (MAX_WINDOW),
    .MAX_READ_HASHES (MAX_READ_HASHES)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .in_req     (in_data),
    .win_len    (win_len),
    .prev_value (chain_value[sel]),
    .prev_pos   (chain_pos[sel]),
    .store      (store),
    .cur_pos    (cur_pos),
    .res_valid  (res_valid),
    .res        (res),
    .count      (count)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A configuration write is visible in the next cycle.
  a_cfg_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (win_size_r == $past(cfg_data)))
    else $error("window size register did not take the write");

  // A start of read restarts the hash count at one.
  a_read_start : assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.start_of_read) |=> (count == CW'(1)))
    else $error("start of read did not restart the hash count");

  // Every result of an accepted request reaches the output register.
  a_result_out : assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid) |=> out_valid_r)
    else $error("result was lost before the output register");

  // A saturated read reports too_long with a zero position.
  a_saturated : assert property (@(posedge clk) disable iff (!rst_n)
    (step && !in_data.start_of_read && (count >= CW'(MAX_READ_HASHES)))
      |=> (out_valid_r && out_data_r.too_long && (out_data_r.position == '0)))
    else $error("request past the read bound was not flagged");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import swm_pkg::*;

  // Scoreboard: predicts the minimizer stream and checks each result in order.
  class minimizer_scoreboard;
    logic [HashWidth-1:0] ring [DefMaxWindow];
    logic [HashWidth-1:0] best_val;
    bit                   best_ok;
    int unsigned          best_pos;
    bit                   sent_ok;
    int unsigned          sent_pos;
    int unsigned          count;
    logic [WinCfgWidth-1:0] win_cfg;
    out_req_t             expected_minima[$];
    int                   errors;

    function new();
      win_cfg = WinSizeReset;
      errors = 0;
      start_read();
    endfunction

    function void start_read();
      best_val = '0;
      best_ok = 1'b0;
      best_pos = 0;
      sent_ok = 1'b0;
      sent_pos = 0;
      count = 0;
    endfunction

    function void set_window(logic [WinCfgWidth-1:0] v);
      win_cfg = v;
    endfunction

    // Works out the result, if any, caused by one accepted hash request.
    function void note_hash(in_req_t req);
      int unsigned w;
      int unsigned p;
      int unsigned left;
      int unsigned q;
      logic [HashWidth-1:0] v;
      out_req_t res;
      if (req.start_of_read) start_read();
      // Past the position bound nothing is stored and a flagged result comes back.
      if (count >= DefMaxReadHashes) begin
        res.minimizer = '0;
        res.position = '0;
        res.too_long = 1'b1;
        expected_minima.insert(expected_minima.size(), res);
        return;
      end
      p = count;
      ring[p % DefMaxWindow] = req.hash_value;
      count = p + 1;
      if (win_cfg == 0) w = 1;
      else if (win_cfg > DefMaxWindow) w = DefMaxWindow;
      else w = win_cfg;
      if (count < w) return;
      left = p + 1 - w;
      // Rescan when the tracked minimum has left the window; ties go to the newer hash.
      if (!best_ok || best_pos < left) begin
        best_val = ring[left % DefMaxWindow];
        best_pos = left;
        for (q = left + 1; q <= p; q++) begin
          v = ring[q % DefMaxWindow];
          if (v <= best_val) begin
            best_val = v;
            best_pos = q;
          end
        end
        best_ok = 1'b1;
      end else if (req.hash_value <= best_val) begin
        best_val = req.hash_value;
        best_pos = p;
      end
      if (!sent_ok || best_pos > sent_pos) begin
        sent_ok = 1'b1;
        sent_pos = best_pos;
        res.minimizer = best_val;
        res.position = best_pos[PosOutWidth-1:0];
        res.too_long = (best_pos > 32'hFFFF);
        expected_minima.insert(expected_minima.size(), res);
      end
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(out_req_t got);
      out_req_t want;
      if (expected_minima.size() == 0) begin
        if (errors < 100)
          $display("%0t: unexpected result minimizer=%h position=%0d too_long=%0b",
                   $time, got.minimizer, got.position, got.too_long);
        errors++;
        return;
      end
      want = expected_minima.pop_front();
      if (got.minimizer !== want.minimizer) begin
        if (errors < 100)
          $display("%0t: minimizer expected %h actual %h", $time, want.minimizer,
                   got.minimizer);
        errors++;
      end
      if (got.position !== want.position) begin
        if (errors < 100)
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   got.position);
        errors++;
      end
      if (got.too_long !== want.too_long) begin
        if (errors < 100)
          $display("%0t: too_long expected %0b actual %0b", $time, want.too_long,
                   got.too_long);
        errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 4000000;
  localparam int RandomItems = 1050;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_req_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WinCfgWidth-1:0] cfg_data = '0;

  minimizer_scoreboard sb = new();
  bit calm = 1'b0;
  int items_sent = 0;
  int cycles = 0;
  logic [HashWidth-1:0] ramp = 64'h8000_0000_0000_0000;

  sliding_window_minimizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch all three channels; values read here are those before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_window(cfg_data);
      if (in_valid && in_ready) sb.note_hash(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: random stalls before taking each result.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Sends one hash request after a random gap and waits for it to be taken.
  task automatic send_hash(logic [HashWidth-1:0] h, logic sor);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{hash_value: h, start_of_read: sor};
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  // Holds the input off until every expected result has come and the pipe is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_minima.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_size(logic [WinCfgWidth-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // Hash patterns: full random, a tiny set for ties, extremes, and ramps both ways.
  function automatic logic [HashWidth-1:0] gen_hash(int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? '1 : 64'($urandom_range(0, 1));
      3: begin
        ramp = ramp - 64'($urandom_range(0, 3));
        return ramp;
      end
      default: begin
        ramp = ramp + 64'($urandom_range(0, 3));
        return ramp;
      end
    endcase
  endfunction

  function automatic logic [WinCfgWidth-1:0] pick_window();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd64;
      3: return 7'($urandom_range(1, 8));
      4: return 7'($urandom_range(1, 64));
      default: return 7'($urandom_range(65, 126));
    endcase
  endfunction

  // Main sequence.
  initial begin
    int i;
    int n;
    int mode;
    int start_odds;
    logic [HashWidth-1:0] h;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset window size, no leading start flag; extremes, a tie on zero, a late maximum.
    for (i = 0; i < 18; i++) begin
      case (i)
        0, 17: h = '1;
        5, 9: h = '0;
        default: h = 64'h0123_4567_89AB_CDEF + 64'(i * 7);
      endcase
      send_hash(h, 1'b0);
    end
    // Size zero acts as one; equal hashes still move the position forward.
    drain_results();
    write_window_size(7'd0);
    send_hash('1, 1'b1);
    send_hash('1, 1'b0);
    send_hash('0, 1'b0);
    send_hash('0, 1'b0);
    // Oversized window acts as the maximum; a short read gives nothing yet.
    drain_results();
    write_window_size(7'd127);
    send_hash(64'hFFFF_0000_FFFF_0000, 1'b1);
    send_hash(64'h0000_FFFF_0000_FFFF, 1'b0);
    send_hash(64'h5555_AAAA_5555_AAAA, 1'b0);

    // Random phases; reads carry across window changes.
    n = items_sent + RandomItems;
    while (items_sent < n) begin
      drain_results();
      write_window_size(pick_window());
      calm = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 4);
      start_odds = $urandom_range(10, 200);
      repeat ($urandom_range(20, 120)) begin
        if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 4);
        send_hash(gen_hash(mode), $urandom_range(0, start_odds - 1) == 0);
        if ($urandom_range(0, 199) == 0) drain_results();
      end
    end

    // A start flag brings the read state back.
    calm = 1'b0;
    drain_results();
    write_window_size(7'd2);
    send_hash(gen_hash(0), 1'b1);
    repeat (10) send_hash(gen_hash(0), 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.expected_minima.size() != 0)
      $display("%0t: %0d expected results never arrived", $time,
               sb.expected_minima.size());
    if (sb.errors == 0 && sb.expected_minima.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/swm_pkg.sv
design/swm_cell.sv
design/swm_tracker.sv
design/sliding_window_minimizer.sv
sim/tb.sv
